/* src/tls_pkg.sv */
// Shared types and constants for the text line splitter.
// No dependencies; imported by every module of the block.
package tls_pkg;

  // Transaction command codes on the input channel
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kind codes
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TERM_PRIMARY      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TERM_SECONDARY_ON = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TERM_SECONDARY    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CR_STRIP_ON       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CR_BYTE           = 3'd4;

  localparam int unsigned CFG_DATA_BITS = 8;

  // Line total counter, saturating
  localparam int unsigned TOTAL_BITS = 21;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  typedef struct packed {
    logic [7:0] term_primary;
    logic       term_secondary_on;
    logic [7:0] term_secondary;
    logic       cr_strip_on;
    logic [7:0] cr_byte;
  } cfg_t;

  typedef struct packed {
    logic is_term;
    logic is_cr;
  } byte_class_t;

endpackage

/* src/tls_cfg_regs.sv */
// Configuration register file of the text line splitter.
// Depends on tls_pkg (cfg_t, register indexes).
module tls_cfg_regs
  import tls_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.term_primary      <= 8'd10;
      cfg_r.term_secondary_on <= 1'b0;
      cfg_r.term_secondary    <= 8'd13;
      cfg_r.cr_strip_on       <= 1'b1;
      cfg_r.cr_byte           <= 8'd13;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TERM_PRIMARY:      cfg_r.term_primary      <= cfg_wdata;
        REG_TERM_SECONDARY_ON: cfg_r.term_secondary_on <= cfg_wdata[0];
        REG_TERM_SECONDARY:    cfg_r.term_secondary    <= cfg_wdata;
        REG_CR_STRIP_ON:       cfg_r.cr_strip_on       <= cfg_wdata[0];
        REG_CR_BYTE:           cfg_r.cr_byte           <= cfg_wdata;
        default: ; // unmapped index, ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/tls_classify.sv */
// Byte classifier: compares the incoming byte against the terminator and CR values.
// Depends on tls_pkg (cfg_t, byte_class_t).
module tls_classify
  import tls_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [7:0]  data_byte,
  output byte_class_t cls
);

  assign cls.is_term = (data_byte == cfg.term_primary) ||
                       (cfg.term_secondary_on && (data_byte == cfg.term_secondary));
  assign cls.is_cr   = (data_byte == cfg.cr_byte);

endmodule

/* src/tls_tracker.sv */
// Line tracker: scan state, line decision logic and the result register.
// Depends on tls_pkg (cfg_t, byte_class_t, command and kind codes).
module tls_tracker
  import tls_pkg::*;
#(
  parameter int unsigned MAX_LINE    = 1024,
  parameter int unsigned OFFSET_BITS = 20,
  parameter int unsigned LEN_BITS    = $clog2(MAX_LINE + 2)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  byte_class_t            cls,
  input  logic                   in_valid,
  input  logic                   in_cmd,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_kind,
  output logic [OFFSET_BITS-1:0] out_line_start,
  output logic [LEN_BITS-1:0]    out_line_length,
  output logic                   out_cr_seen,
  output logic                   out_broken,
  output logic [TOTAL_BITS-1:0]  out_line_total
);

  localparam logic [LEN_BITS-1:0]    MAX_LEN = LEN_BITS'(MAX_LINE);
  localparam logic [OFFSET_BITS-1:0] MAX_OFF = OFFSET_BITS'(MAX_LINE);

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [LEN_BITS-1:0]    pend_r, pend_nxt;
  logic                   prev_cr_r, prev_cr_nxt;
  logic [TOTAL_BITS-1:0]  total_r, total_nxt;

  logic                   out_valid_r;
  logic                   kind_r;
  logic [OFFSET_BITS-1:0] start_out_r;
  logic [LEN_BITS-1:0]    len_r;
  logic                   cr_r;
  logic                   brk_r;
  logic [TOTAL_BITS-1:0]  tot_r;

  logic                   accept;
  logic                   emit;
  logic                   strip;
  logic                   e_kind;
  logic [OFFSET_BITS-1:0] e_start;
  logic [LEN_BITS-1:0]    e_len;
  logic                   e_cr;
  logic                   e_brk;
  logic [TOTAL_BITS-1:0]  e_total;
  logic [TOTAL_BITS-1:0]  total_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign total_inc = (total_r != TOTAL_MAX) ? total_r + 1'b1 : total_r;

  always_comb begin
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    pend_nxt    = pend_r;
    prev_cr_nxt = prev_cr_r;
    total_nxt   = total_r;
    emit        = 1'b0;
    strip       = 1'b0;
    e_kind      = KIND_LINE;
    e_start     = start_r;
    e_len       = pend_r;
    e_cr        = 1'b0;
    e_brk       = 1'b0;
    e_total     = '0;
    if (accept) begin
      if (in_cmd == CMD_END) begin
        emit        = 1'b1;
        e_kind      = KIND_END;
        e_total     = total_r;
        pos_nxt     = '0;
        start_nxt   = '0;
        pend_nxt    = '0;
        prev_cr_nxt = 1'b0;
        total_nxt   = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (cls.is_term) begin
          // held CR beyond the limit is always stripped
          strip       = (pend_r > MAX_LEN) ||
                        (cfg.cr_strip_on && (pend_r != '0) && prev_cr_r);
          emit        = 1'b1;
          e_len       = strip ? pend_r - 1'b1 : pend_r;
          e_cr        = strip;
          total_nxt   = total_inc;
          start_nxt   = pos_r + 1'b1;
          pend_nxt    = '0;
          prev_cr_nxt = 1'b0;
        end else if (pend_r < MAX_LEN) begin
          pend_nxt    = pend_r + 1'b1;
          prev_cr_nxt = cls.is_cr;
        end else if ((pend_r == MAX_LEN) && cfg.cr_strip_on && cls.is_cr) begin
          pend_nxt    = pend_r + 1'b1;
          prev_cr_nxt = 1'b1;
        end else begin
          // cut at the limit; a held CR moves into the next line
          emit        = 1'b1;
          e_len       = MAX_LEN;
          e_brk       = 1'b1;
          total_nxt   = total_inc;
          start_nxt   = start_r + MAX_OFF;
          pend_nxt    = (pend_r > MAX_LEN) ? LEN_BITS'(2) : LEN_BITS'(1);
          prev_cr_nxt = cls.is_cr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      start_r     <= '0;
      pend_r      <= '0;
      prev_cr_r   <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      pend_r    <= pend_nxt;
      prev_cr_r <= prev_cr_nxt;
      total_r   <= total_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r      <= e_kind;
      start_out_r <= e_start;
      len_r       <= e_len;
      cr_r        <= e_cr;
      brk_r       <= e_brk;
      tot_r       <= e_total;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_line_start  = start_out_r;
  assign out_line_length = len_r;
  assign out_cr_seen     = cr_r;
  assign out_broken      = brk_r;
  assign out_line_total  = tot_r;

endmodule

/* src/text_line_splitter_core.sv */
// Top level of the text line splitter: config registers, byte classifier, tracker.
// Depends on tls_pkg, tls_cfg_regs, tls_classify and tls_tracker.
//
// The core scans a text buffer one byte per transaction and reports each line
// as it closes: start offset, length, CR-strip mark and a broken flag for lines
// cut at MAX_LINE bytes. An end-of-buffer transaction reports the unterminated
// remainder with the running line total and clears the scan state. Throughput
// is one transaction per clock: each byte needs only three byte compares and
// the counter updates of the tracker, all in front of the result register. A
// result appears on the out_ channel the cycle after the byte that closes the
// line. in_ready drops only while a result sits in the result register and
// out_ready is low; any byte that closes no line still needs that register
// free, so the source stalls one for one with the sink. Configuration writes
// take effect on the next cycle and must be made with the block idle.
module text_line_splitter_core
  import tls_pkg::*;
#(
  parameter int unsigned MAX_LINE    = 1024,
  parameter int unsigned OFFSET_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [7:0]                    in_data_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [OFFSET_BITS-1:0]        out_line_start,
  output logic [$clog2(MAX_LINE+2)-1:0] out_line_length,
  output logic                          out_cr_seen,
  output logic                          out_broken,
  output logic [TOTAL_BITS-1:0]         out_line_total
);

  localparam int unsigned LEN_BITS = $clog2(MAX_LINE + 2);

  cfg_t        cfg;
  byte_class_t cls;

  tls_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  // terminator wins over CR when a byte matches both
  tls_classify u_cls (
    .cfg      (cfg),
    .data_byte(in_data_byte),
    .cls      (cls)
  );

  tls_tracker #(
    .MAX_LINE   (MAX_LINE),
    .OFFSET_BITS(OFFSET_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_trk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cls            (cls),
    .in_valid       (in_valid),
    .in_cmd         (in_cmd),
    .in_ready       (in_ready),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_line_start (out_line_start),
    .out_line_length(out_line_length),
    .out_cr_seen    (out_cr_seen),
    .out_broken     (out_broken),
    .out_line_total (out_line_total)
  );

endmodule

/* src/tls_checker.sv */
// Port-level checker for the text line splitter, bound to the top level.
// Depends on tls_pkg (kind and command codes, TOTAL_BITS).
module tls_checker
  import tls_pkg::*;
#(
  parameter int unsigned MAX_LINE = 1024
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_kind,
  input logic [$clog2(MAX_LINE+2)-1:0] out_line_length,
  input logic                          out_cr_seen,
  input logic                          out_broken,
  input logic [TOTAL_BITS-1:0]         out_line_total
);

  localparam int unsigned LEN_BITS = $clog2(MAX_LINE + 2);
  localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_LINE);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // input stalls only behind a blocked result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // broken lines are exactly MAX_LINE long and carry no CR mark
  a_broken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_broken |-> out_kind == KIND_LINE && out_line_length == MAX_LEN &&
    !out_cr_seen)
    else $error("broken line with wrong shape");

  // end report carries no line marks; line results carry no total
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_END && !out_cr_seen && !out_broken) ||
    (out_kind == KIND_LINE && out_line_total == '0))
    else $error("result fields inconsistent with kind");

  // an accepted end transaction always gives a result the next cycle
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_END |=> out_valid && out_kind == KIND_END)
    else $error("end transaction gave no report");

endmodule

bind text_line_splitter_core tls_checker #(
  .MAX_LINE(MAX_LINE)
) u_tls_checker (.*);
